// ===== hdl/mrs_pkg.sv =====
// shared types, widths and codes for the ultrasonic ranging sequencer
package mrs_pkg;

    localparam int SENSOR_COUNT = 3;
    localparam int LINE_COUNT   = 3;
    localparam int SENSOR_W     = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    localparam int ECHO_W      = 3;
    localparam int TRIG_W      = 3;
    localparam int SENS_OUT_W  = 2;
    localparam int DIST_W      = 17;
    localparam int TLEN_W      = 8;
    localparam int TMO_W       = 16;
    localparam int GAP_W       = 20;
    localparam int SCALE_W     = 18;
    localparam int CNT_W       = 20;
    localparam int PW_W        = 16;
    localparam int FRAC_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_RISE = 3'd2,
        PH_MEAS = 3'd3,
        PH_GAP  = 3'd4,
        PH_RGAP = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_TRIGGER_LEN  = 3'd1,
        REG_ECHO_TIMEOUT = 3'd2,
        REG_SENSOR_GAP   = 3'd3,
        REG_ROUND_GAP    = 3'd4,
        REG_SCALE        = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                enable;
        logic [TLEN_W-1:0]   trigger_len;
        logic [TMO_W-1:0]    echo_timeout;
        logic [GAP_W-1:0]    sensor_gap;
        logic [GAP_W-1:0]    round_gap;
        logic [SCALE_W-1:0]  scale;
    } cfg_t;

    // last member sits in the lowest bits, so the struct maps straight onto m_tdata
    typedef struct packed {
        logic                  update_timeout;
        logic [DIST_W-1:0]     update_distance;
        logic [SENS_OUT_W-1:0] update_sensor;
        logic                  update_valid;
        logic [TRIG_W-1:0]     trigger_lines;
    } result_t;

endpackage

// ===== hdl/mrs_dist.sv =====
// pulse width to distance: q16 scale, round half up, saturate
module mrs_dist (
    input  logic [mrs_pkg::PW_W-1:0]    pulse_width,
    input  logic [mrs_pkg::SCALE_W-1:0] scale,
    output logic [mrs_pkg::DIST_W-1:0]  distance
);
    import mrs_pkg::*;

    localparam int PROD_W = PW_W + SCALE_W + 1;
    localparam int SHR_W  = PROD_W - FRAC_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

    logic [PROD_W-1:0] prod;
    logic [SHR_W-1:0]  shifted;

    always_comb begin
        prod    = PROD_W'(pulse_width) * PROD_W'(scale) + HALF;
        shifted = prod[PROD_W-1:FRAC_W];
        if (|shifted[SHR_W-1:DIST_W]) begin
            distance = '1;
        end else begin
            distance = shifted[DIST_W-1:0];
        end
    end

endmodule

// ===== hdl/mrs_core.sv =====
// sequencing state machine: trigger, echo wait, pulse measure, gaps
module mrs_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mrs_pkg::cfg_t                cfg,
    input  logic                         step,
    input  logic [mrs_pkg::ECHO_W-1:0]   echo,
    output mrs_pkg::result_t             result
);
    import mrs_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [SENSOR_W-1:0]   sensor_reg, sensor_next;
    logic [CNT_W-1:0]      tick_reg, tick_next;
    logic [PW_W-1:0]       pw_reg, pw_next;

    logic [CNT_W-1:0]      tick_inc;
    logic [SENSOR_W:0]     sensor_inc;
    logic [TRIG_W-1:0]     line_sel;
    logic                  echo_hi;
    logic [DIST_W-1:0]     distance;

    mrs_dist u_dist (
        .pulse_width (pw_reg),
        .scale       (cfg.scale),
        .distance    (distance)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            sensor_reg <= '0;
            tick_reg   <= '0;
            pw_reg     <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            sensor_reg <= sensor_next;
            tick_reg   <= tick_next;
            pw_reg     <= pw_next;
        end
    end

    always_comb begin
        // sensors past the physical lines see a low echo and drive nothing
        for (int i = 0; i < LINE_COUNT; i++) begin
            line_sel[i] = (32'(sensor_reg) == i);
        end
        echo_hi    = |(echo & line_sel);
        tick_inc   = tick_reg + CNT_W'(1);
        sensor_inc = {1'b0, sensor_reg} + (SENSOR_W+1)'(1);

        phase_next  = phase_reg;
        sensor_next = sensor_reg;
        tick_next   = tick_reg;
        pw_next     = pw_reg;

        result                 = '0;
        result.update_sensor   = SENS_OUT_W'(sensor_reg);

        case (phase_reg)
            PH_TRIG: begin
                result.trigger_lines = line_sel;
                tick_next = tick_inc;
                if (tick_inc >= CNT_W'(cfg.trigger_len)) begin
                    phase_next = PH_RISE;
                    tick_next  = '0;
                end
            end
            PH_RISE: begin
                if (echo_hi) begin
                    phase_next = PH_MEAS;
                    pw_next    = PW_W'(1);
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc >= CNT_W'(cfg.echo_timeout)) begin
                        result.update_valid   = 1'b1;
                        result.update_timeout = 1'b1;
                        phase_next = PH_GAP;
                        tick_next  = '0;
                    end
                end
            end
            PH_MEAS: begin
                if (echo_hi) begin
                    if (pw_reg >= cfg.echo_timeout) begin
                        result.update_valid   = 1'b1;
                        result.update_timeout = 1'b1;
                        phase_next = PH_GAP;
                        tick_next  = '0;
                    end else begin
                        pw_next = pw_reg + PW_W'(1);
                    end
                end else begin
                    result.update_valid    = 1'b1;
                    result.update_distance = distance;
                    phase_next = PH_GAP;
                    tick_next  = '0;
                end
            end
            PH_GAP: begin
                tick_next = tick_inc;
                if (tick_inc >= cfg.sensor_gap) begin
                    tick_next = '0;
                    if (32'(sensor_inc) < SENSOR_COUNT) begin
                        sensor_next = sensor_inc[SENSOR_W-1:0];
                        phase_next  = PH_TRIG;
                    end else begin
                        phase_next = PH_RGAP;
                    end
                end
            end
            PH_RGAP: begin
                tick_next = tick_inc;
                if (tick_inc >= cfg.round_gap) begin
                    tick_next   = '0;
                    sensor_next = '0;
                    phase_next  = cfg.enable ? PH_TRIG : PH_IDLE;
                end
            end
            default: begin
                tick_next   = '0;
                sensor_next = '0;
                phase_next  = cfg.enable ? PH_TRIG : PH_IDLE;
            end
        endcase

        if (!result.update_valid) begin
            result.update_sensor = '0;
        end
    end

endmodule

// ===== hdl/multi_ultrasonic_ranging_sequencer.sv =====
// Ultrasonic ranging sequencer for several trigger/echo sensor pairs. Each input word is one
// microsecond tick carrying the sampled echo lines, and each tick gives exactly one result word
// with the trigger drive and, when a reading finishes, the sensor index and distance in
// hundredths of a cm (or a timeout flag). Throughput is one word per clock while m_tready is high;
// an accepted word passes through the input register and then the result register, between which
// the whole tick update and the 16x18 distance multiply run. While a result waits on m_tready the
// input register takes at most one more word, then s_tready drops. Configuration writes are always
// taken and belong to idle periods.
module multi_ultrasonic_ranging_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // [2:0] echo_levels
    input  logic [mrs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] trigger_lines, [3] update_valid, [5:4] update_sensor,
    // [22:6] update_distance, [23] update_timeout
    output logic [mrs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mrs_pkg::*;

    cfg_t                cfg_reg;
    logic                in_valid_reg, in_valid_next;
    logic [ECHO_W-1:0]   echo_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg;
    result_t             result;
    logic                advance;
    logic                step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.trigger_len  <= TLEN_W'(10);
            cfg_reg.echo_timeout <= TMO_W'(10000);
            cfg_reg.sensor_gap   <= GAP_W'(20000);
            cfg_reg.round_gap    <= GAP_W'(10000);
            cfg_reg.scale        <= SCALE_W'(112394);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_ENABLE:       cfg_reg.enable       <= cfg_data[0];
                REG_TRIGGER_LEN:  cfg_reg.trigger_len  <= cfg_data[TLEN_W-1:0];
                REG_ECHO_TIMEOUT: cfg_reg.echo_timeout <= cfg_data[TMO_W-1:0];
                REG_SENSOR_GAP:   cfg_reg.sensor_gap   <= cfg_data[GAP_W-1:0];
                REG_ROUND_GAP:    cfg_reg.round_gap    <= cfg_data[GAP_W-1:0];
                REG_SCALE:        cfg_reg.scale        <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // the result register moves whenever it is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            echo_reg <= s_tdata[ECHO_W-1:0];
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    mrs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .echo    (echo_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/mrs_checker.sv =====
// port-level checks for the ultrasonic ranging sequencer, bound to the top level
module mrs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic [mrs_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // without an update, sensor, distance and timeout are all zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[23:4] == 20'd0)
        else $error("update fields set without update_valid");

    // a timeout is an update with no distance
    a_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> m_tdata[3] && m_tdata[22:6] == 17'd0)
        else $error("timeout word malformed");

    // at most one trigger at a time
    a_one_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[2:0]))
        else $error("more than one trigger line driven");

    // triggering and a finished reading never share a tick
    a_trig_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'd0)
        else $error("trigger driven on an update tick");

endmodule

bind multi_ultrasonic_ranging_sequencer mrs_checker u_mrs_checker (.*);
